### hw/rtl/tpo_pkg.sv
// tpo_pkg: shared types and constants of the triangle pair overlap test.
// Used by every module under hw/rtl; depends on nothing.
package tpo_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int WORD_BITS          = 32;
   localparam int VERTICES           = 6;
   localparam int EDGES              = 6;
   localparam int ORIENTS            = 18;
   localparam int LATENCY            = 5;

   typedef struct packed {
      logic valid;
      logic point_mode;
   } ctl_type;

   typedef struct packed {
      logic zero;
      logic neg;
   } orient_type;

   function automatic int next3(input int i);
      return (i == 2) ? 0 : i + 1;
   endfunction

endpackage

### hw/rtl/tpo_diff.sv
// tpo_diff: request register, coordinate unpack, edge and offset vectors, box tests.
// Depends on tpo_pkg.
module tpo_diff #(
   parameter int COORD_BITS = tpo_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  tpo_pkg::ctl_type                                      ctl_i,
   input  logic [tpo_pkg::VERTICES-1:0][tpo_pkg::WORD_BITS-1:0]  vertex_i,
   output tpo_pkg::ctl_type                                      ctl_o,
   output logic [tpo_pkg::EDGES-1:0][COORD_BITS:0]               ex_o,
   output logic [tpo_pkg::EDGES-1:0][COORD_BITS:0]               ey_o,
   output logic [tpo_pkg::ORIENTS-1:0][COORD_BITS:0]             wx_o,
   output logic [tpo_pkg::ORIENTS-1:0][COORD_BITS:0]             wy_o,
   output logic [tpo_pkg::ORIENTS-1:0]                           box_o
);
   localparam int DW = COORD_BITS + 1;
   localparam int XW = (2 * COORD_BITS > tpo_pkg::WORD_BITS) ? 2 * COORD_BITS
                                                              : tpo_pkg::WORD_BITS;

   tpo_pkg::ctl_type ctl1_ff, ctl2_ff;
   logic [tpo_pkg::VERTICES-1:0][COORD_BITS-1:0] px_ff, py_ff, px_in, py_in;
   logic [tpo_pkg::EDGES-1:0][DW-1:0]   ex_ff, ey_ff, ex_in, ey_in;
   logic [tpo_pkg::ORIENTS-1:0][DW-1:0] wx_ff, wy_ff, wx_in, wy_in;
   logic [tpo_pkg::ORIENTS-1:0]         box_ff, box_in;

   always_comb begin
      logic [XW-1:0] ext;
      for (int v = 0; v < tpo_pkg::VERTICES; v++) begin
         ext      = XW'(vertex_i[v]);
         px_in[v] = ext[COORD_BITS-1:0];
         py_in[v] = ext[2*COORD_BITS-1:COORD_BITS];
      end
   end

   always_comb begin
      logic signed [COORD_BITS-1:0] xp, yp, xq, yq, xr, yr;
      logic inx, iny;
      int p, q, r, e, n;
      for (int t = 0; t < 2; t++) begin
         for (int i = 0; i < 3; i++) begin
            p = t * 3 + i;
            q = t * 3 + tpo_pkg::next3(i);
            e = p;
            xp = $signed(px_ff[p]);
            yp = $signed(py_ff[p]);
            xq = $signed(px_ff[q]);
            yq = $signed(py_ff[q]);
            ex_in[e] = DW'(xq) - DW'(xp);
            ey_in[e] = DW'(yq) - DW'(yp);
            for (int k = 0; k < 3; k++) begin
               r  = (1 - t) * 3 + k;
               n  = t * 9 + i * 3 + k;
               xr = $signed(px_ff[r]);
               yr = $signed(py_ff[r]);
               wx_in[n] = DW'(xr) - DW'(xq);
               wy_in[n] = DW'(yr) - DW'(yq);
               inx = (xr >= xp && xr <= xq) || (xr >= xq && xr <= xp);
               iny = (yr >= yp && yr <= yq) || (yr >= yq && yr <= yp);
               box_in[n] = inx && iny;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else begin
         ctl1_ff <= ctl_i;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      px_ff  <= px_in;
      py_ff  <= py_in;
      ex_ff  <= ex_in;
      ey_ff  <= ey_in;
      wx_ff  <= wx_in;
      wy_ff  <= wy_in;
      box_ff <= box_in;
   end

   assign ctl_o = ctl2_ff;
   assign ex_o  = ex_ff;
   assign ey_o  = ey_ff;
   assign wx_o  = wx_ff;
   assign wy_o  = wy_ff;
   assign box_o = box_ff;

endmodule

### hw/rtl/tpo_mult.sv
// tpo_mult: registered products of edge and offset components for all orientations.
// Depends on tpo_pkg.
module tpo_mult #(
   parameter int COORD_BITS = tpo_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  tpo_pkg::ctl_type                                   ctl_i,
   input  logic [tpo_pkg::EDGES-1:0][COORD_BITS:0]            ex_i,
   input  logic [tpo_pkg::EDGES-1:0][COORD_BITS:0]            ey_i,
   input  logic [tpo_pkg::ORIENTS-1:0][COORD_BITS:0]          wx_i,
   input  logic [tpo_pkg::ORIENTS-1:0][COORD_BITS:0]          wy_i,
   input  logic [tpo_pkg::ORIENTS-1:0]                        box_i,
   output tpo_pkg::ctl_type                                   ctl_o,
   output logic [tpo_pkg::ORIENTS-1:0][2*COORD_BITS+1:0]      p1_o,
   output logic [tpo_pkg::ORIENTS-1:0][2*COORD_BITS+1:0]      p2_o,
   output logic [tpo_pkg::ORIENTS-1:0]                        box_o
);
   localparam int PW = 2 * COORD_BITS + 2;

   tpo_pkg::ctl_type ctl_ff;
   logic [tpo_pkg::ORIENTS-1:0][PW-1:0] p1_ff, p2_ff, p1_in, p2_in;
   logic [tpo_pkg::ORIENTS-1:0]         box_ff;

   always_comb begin
      logic signed [PW-1:0] exs, eys, wxs, wys;
      int e, n;
      for (int t = 0; t < 2; t++) begin
         for (int i = 0; i < 3; i++) begin
            e = t * 3 + i;
            for (int k = 0; k < 3; k++) begin
               n   = t * 9 + i * 3 + k;
               exs = PW'($signed(ex_i[e]));
               eys = PW'($signed(ey_i[e]));
               wxs = PW'($signed(wx_i[n]));
               wys = PW'($signed(wy_i[n]));
               p1_in[n] = eys * wxs;
               p2_in[n] = exs * wys;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      box_ff <= box_i;
   end

   assign ctl_o = ctl_ff;
   assign p1_o  = p1_ff;
   assign p2_o  = p2_ff;
   assign box_o = box_ff;

endmodule

### hw/rtl/tpo_orient.sv
// tpo_orient: subtracts product pairs and registers the sign of each orientation.
// Depends on tpo_pkg.
module tpo_orient #(
   parameter int COORD_BITS = tpo_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  tpo_pkg::ctl_type                               ctl_i,
   input  logic [tpo_pkg::ORIENTS-1:0][2*COORD_BITS+1:0]  p1_i,
   input  logic [tpo_pkg::ORIENTS-1:0][2*COORD_BITS+1:0]  p2_i,
   input  logic [tpo_pkg::ORIENTS-1:0]                    box_i,
   output tpo_pkg::ctl_type                               ctl_o,
   output tpo_pkg::orient_type [tpo_pkg::ORIENTS-1:0]     orient_o,
   output logic [tpo_pkg::ORIENTS-1:0]                    box_o
);
   localparam int VW = 2 * COORD_BITS + 3;

   tpo_pkg::ctl_type ctl_ff;
   tpo_pkg::orient_type [tpo_pkg::ORIENTS-1:0] orient_ff, orient_in;
   logic [tpo_pkg::ORIENTS-1:0] box_ff;

   always_comb begin
      logic [VW-1:0] v;
      for (int n = 0; n < tpo_pkg::ORIENTS; n++) begin
         v = VW'($signed(p1_i[n])) - VW'($signed(p2_i[n]));
         orient_in[n].zero = (v == '0);
         orient_in[n].neg  = v[VW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      orient_ff <= orient_in;
      box_ff    <= box_i;
   end

   assign ctl_o    = ctl_ff;
   assign orient_o = orient_ff;
   assign box_o    = box_ff;

endmodule

### hw/rtl/tpo_combine.sv
// tpo_combine: point-in-triangle and edge-pair decisions, registered hit strobe.
// Depends on tpo_pkg.
module tpo_combine (
   input  logic                                        clock,
   input  logic                                        reset,
   input  tpo_pkg::ctl_type                            ctl_i,
   input  tpo_pkg::orient_type [tpo_pkg::ORIENTS-1:0]  orient_i,
   input  logic [tpo_pkg::ORIENTS-1:0]                 box_i,
   output logic                                        valid_o,
   output logic                                        hit_o
);
   logic valid_ff;
   logic hit_ff, hit_in;

   function automatic logic inside3(input tpo_pkg::orient_type o0,
                                    input tpo_pkg::orient_type o1,
                                    input tpo_pkg::orient_type o2);
      logic neg, pos;
      neg = o0.neg || o1.neg || o2.neg;
      pos = (!o0.zero && !o0.neg) || (!o1.zero && !o1.neg) || (!o2.zero && !o2.neg);
      return !(neg && pos);
   endfunction

   always_comb begin
      logic any;
      int n1, n2, n3, n4;
      any = 1'b0;
      // vertices of one triangle against the other
      for (int k = 0; k < 3; k++) begin
         any = any || inside3(orient_i[9 + k], orient_i[12 + k], orient_i[15 + k]);
         any = any || inside3(orient_i[k], orient_i[3 + k], orient_i[6 + k]);
      end
      // edge pairs
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            n1 = i * 3 + j;
            n2 = i * 3 + tpo_pkg::next3(j);
            n3 = 9 + j * 3 + i;
            n4 = 9 + j * 3 + tpo_pkg::next3(i);
            any = any || ((orient_i[n1] != orient_i[n2]) && (orient_i[n3] != orient_i[n4]));
            any = any || (orient_i[n1].zero && box_i[n1]);
            any = any || (orient_i[n2].zero && box_i[n2]);
            any = any || (orient_i[n3].zero && box_i[n3]);
            any = any || (orient_i[n4].zero && box_i[n4]);
         end
      end
      if (ctl_i.point_mode) begin
         hit_in = inside3(orient_i[9], orient_i[12], orient_i[15]);
      end else begin
         hit_in = any;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
   end

   assign valid_o = valid_ff;
   assign hit_o   = hit_ff;

   // a point on all three (degenerate) edge lines of triangle b counts as inside
   a_point_degenerate: assert property (@(posedge clock) disable iff (reset)
      (ctl_i.valid && ctl_i.point_mode && orient_i[9].zero && orient_i[12].zero &&
       orient_i[15].zero) |=> (valid_ff && hit_ff))
      else $error("point on degenerate triangle not reported as hit");

endmodule

### hw/rtl/triangle_pair_overlap_test.sv
// Triangle pair overlap test: one request carries two 2D triangles a and b
// (six packed vertices, x in the low lane, y in the next, signed two's complement)
// and a point_mode flag. One response carries a single hit bit.
// Request channel: a request is taken at a rising edge with start high and busy
// low. busy is never raised: the pipeline takes a new request every cycle.
// Response channel: rsp_valid is high for exactly one cycle with rsp_hit valid
// in that cycle; the receiver cannot hold responses off, and none is needed.
// Pipeline: input register, vector differences, multiplier stage, sign stage,
// decision stage. Throughput is one request per cycle, set by the 36 parallel
// products in the multiplier stage. Responses come out in request order.
// Reset (synchronous, active high) clears every stage valid bit; requests in
// flight are dropped and no response appears for them.
// Depends on tpo_pkg, tpo_diff, tpo_mult, tpo_orient, tpo_combine.
module triangle_pair_overlap_test #(
   parameter int COORD_BITS = tpo_pkg::COORD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_point_mode,
   input  logic [tpo_pkg::WORD_BITS-1:0]  req_a_vertex0,
   input  logic [tpo_pkg::WORD_BITS-1:0]  req_a_vertex1,
   input  logic [tpo_pkg::WORD_BITS-1:0]  req_a_vertex2,
   input  logic [tpo_pkg::WORD_BITS-1:0]  req_b_vertex0,
   input  logic [tpo_pkg::WORD_BITS-1:0]  req_b_vertex1,
   input  logic [tpo_pkg::WORD_BITS-1:0]  req_b_vertex2,
   output logic                           rsp_valid,
   output logic                           rsp_hit
);
   tpo_pkg::ctl_type req_ctl, diff_ctl, mult_ctl, orient_ctl;
   logic [tpo_pkg::VERTICES-1:0][tpo_pkg::WORD_BITS-1:0] vertex;
   logic [tpo_pkg::EDGES-1:0][COORD_BITS:0]        ex, ey;
   logic [tpo_pkg::ORIENTS-1:0][COORD_BITS:0]      wx, wy;
   logic [tpo_pkg::ORIENTS-1:0][2*COORD_BITS+1:0]  p1, p2;
   logic [tpo_pkg::ORIENTS-1:0] diff_box, mult_box, orient_box;
   tpo_pkg::orient_type [tpo_pkg::ORIENTS-1:0] orient;

   assign busy = 1'b0;

   assign req_ctl.valid      = start && !busy;
   assign req_ctl.point_mode = req_point_mode;

   assign vertex[0] = req_a_vertex0;
   assign vertex[1] = req_a_vertex1;
   assign vertex[2] = req_a_vertex2;
   assign vertex[3] = req_b_vertex0;
   assign vertex[4] = req_b_vertex1;
   assign vertex[5] = req_b_vertex2;

   tpo_diff #(.COORD_BITS(COORD_BITS)) u_diff (
      .clock    (clock),
      .reset    (reset),
      .ctl_i    (req_ctl),
      .vertex_i (vertex),
      .ctl_o    (diff_ctl),
      .ex_o     (ex),
      .ey_o     (ey),
      .wx_o     (wx),
      .wy_o     (wy),
      .box_o    (diff_box)
   );

   tpo_mult #(.COORD_BITS(COORD_BITS)) u_mult (
      .clock (clock),
      .reset (reset),
      .ctl_i (diff_ctl),
      .ex_i  (ex),
      .ey_i  (ey),
      .wx_i  (wx),
      .wy_i  (wy),
      .box_i (diff_box),
      .ctl_o (mult_ctl),
      .p1_o  (p1),
      .p2_o  (p2),
      .box_o (mult_box)
   );

   tpo_orient #(.COORD_BITS(COORD_BITS)) u_orient (
      .clock    (clock),
      .reset    (reset),
      .ctl_i    (mult_ctl),
      .p1_i     (p1),
      .p2_i     (p2),
      .box_i    (mult_box),
      .ctl_o    (orient_ctl),
      .orient_o (orient),
      .box_o    (orient_box)
   );

   tpo_combine u_combine (
      .clock    (clock),
      .reset    (reset),
      .ctl_i    (orient_ctl),
      .orient_i (orient),
      .box_i    (orient_box),
      .valid_o  (rsp_valid),
      .hit_o    (rsp_hit)
   );

   a_resp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(tpo_pkg::LATENCY) rsp_valid)
      else $error("request without response after pipeline latency");

   a_no_spurious_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, tpo_pkg::LATENCY))
      else $error("response without matching request");

   a_mode_travels: assert property (@(posedge clock) disable iff (reset)
      orient_ctl.valid |-> $past(req_point_mode, tpo_pkg::LATENCY - 1) ==
                           orient_ctl.point_mode)
      else $error("point mode lost in pipeline");

endmodule
